/* src/assert_macros.svh */
// Assertion macros shared by the matrix multiply RTL.
// Include guard keeps repeated includes harmless.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Assert that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("forbidden condition seen");
`endif

/* src/mm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the matrix multiply block.
// No dependencies.
package mm_pkg;
    localparam int MAX_DIM      = 64;
    localparam int ELEMENT_BITS = 16;
    localparam int IDX_BITS     = $clog2(MAX_DIM);
    localparam int CNT_BITS     = IDX_BITS + 1;
    localparam int ADDR_BITS    = 2 * IDX_BITS;
    localparam int DEPTH        = MAX_DIM * MAX_DIM;
    localparam int OUT_BITS     = 38;
    localparam int CFG_BITS     = 7;

    localparam logic [1:0] REQ_WRITE_A = 2'd0;
    localparam logic [1:0] REQ_WRITE_B = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_COLS  = 2'd1;
    localparam logic [1:0] CFG_INNER = 2'd2;

    // Control passed along the cell chain with each term.
    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last_term;
        logic                last_col;
        logic [IDX_BITS-1:0] col;
    } mm_ctl_t;
endpackage

/* src/mm_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/mm_cell.sv */
`timescale 1ns / 1ps
// One cell of the chain: takes a term and control from its left neighbor,
// registers its part of the work and hands the result to its right neighbor.
// Depends on mm_pkg.
module mm_cell
    import mm_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          mul_en,
    input  logic signed [ELEMENT_BITS-1:0] a_in,
    input  logic signed [ELEMENT_BITS-1:0] b_in,
    input  logic signed [OUT_BITS-1:0]    acc_in,
    input  mm_ctl_t                       ctl_in,
    output logic signed [OUT_BITS-1:0]    acc_out,
    output mm_ctl_t                       ctl_out
);
    logic signed [OUT_BITS-1:0] acc_reg;
    logic signed [OUT_BITS-1:0] acc_next;
    mm_ctl_t                    ctl_reg;

    // Multiply cell when mul_en, otherwise accumulate the incoming product.
    always_comb
    begin
        if (mul_en)
        begin
            acc_next = OUT_BITS'(a_in * b_in);
        end
        else
        begin
            acc_next = ctl_in.first ? acc_in : acc_reg + acc_in;
        end
    end

    // Hold everything while the chain is paused.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && (mul_en || ctl_in.valid))
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;
    assign ctl_out = ctl_reg;
endmodule

/* src/matrix_multiply.sv */
`timescale 1ns / 1ps
// Matrix multiply C = A x B, signed Q8.8 elements, Q22.16 results.
// Request channel (valid/ready): req_type 0 writes an A element, 1 a B
// element, 2 computes one row of C. Requests outside the configured sizes
// are dropped. Config channel (cfg_valid/cfg_ready) writes row_count,
// col_count and inner_count; write it only while the block is idle.
// Writes are accepted back to back.
// A compute emits col_count result transactions in column order, the
// last flagged. One term per cycle, unless the output stalls, is read
// from the two store RAMs and walks a chain of a multiply cell and an
// accumulate cell; a column has max(inner_count, 1) terms, and its
// result reaches the output register after its last term passes the
// read register and the multiply cell. The next request is taken once
// the last result sits in the output register.
// The output register holds a result while the receiver stalls; the
// whole chain then pauses. Reset clears control and restores all sizes
// to 64; the stores are not cleared and must be written before use.
// Depends on mm_pkg, mm_ram, mm_cell and assert_macros.svh.
`include "assert_macros.svh"
module matrix_multiply
    import mm_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid,
    output logic                           ready,
    input  logic [1:0]                     req_type,
    input  logic [IDX_BITS-1:0]            row_index,
    input  logic [IDX_BITS-1:0]            col_index,
    input  logic signed [15:0]             element_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [CFG_BITS-1:0]            cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [IDX_BITS-1:0]            out_row,
    output logic [IDX_BITS-1:0]            out_col,
    output logic signed [OUT_BITS-1:0]     product_value,
    output logic                           last_flag
);
    logic [CFG_BITS-1:0] rows_reg, cols_reg, inner_reg;
    logic [CNT_BITS-1:0] rows_lim, cols_lim, inner_lim;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= CFG_BITS'(MAX_DIM);
            cols_reg  <= CFG_BITS'(MAX_DIM);
            inner_reg <= CFG_BITS'(MAX_DIM);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROWS:  rows_reg  <= cfg_data;
                CFG_COLS:  cols_reg  <= cfg_data;
                CFG_INNER: inner_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    function automatic logic [CNT_BITS-1:0] sat(input logic [CFG_BITS-1:0] v);
        return (v > CFG_BITS'(MAX_DIM)) ? CNT_BITS'(MAX_DIM) : CNT_BITS'(v);
    endfunction

    assign rows_lim  = sat(rows_reg);
    assign cols_lim  = sat(cols_reg);
    assign inner_lim = sat(inner_reg);

    // Sequencer: busy while the terms of a row are being issued.
    logic                busy_reg;
    logic [IDX_BITS-1:0] row_reg;
    logic [CNT_BITS-1:0] col_reg, k_reg;
    logic                stall;
    logic                in_acc;
    logic                issue;

    assign in_acc = valid && ready;
    assign stall  = out_valid && !out_ready;
    assign issue  = busy_reg && !stall;

    logic                 a_we, b_we;
    logic [ADDR_BITS-1:0] waddr, a_raddr, b_raddr;
    logic [ADDR_BITS-1:0] a_raddr_reg, b_raddr_reg;
    logic [ELEMENT_BITS-1:0] a_rd, b_rd;

    assign waddr = {row_index, col_index};
    assign a_we  = in_acc && (req_type == REQ_WRITE_A)
                   && (CNT_BITS'(row_index) < rows_lim)
                   && (CNT_BITS'(col_index) < inner_lim);
    assign b_we  = in_acc && (req_type == REQ_WRITE_B)
                   && (CNT_BITS'(row_index) < inner_lim)
                   && (CNT_BITS'(col_index) < cols_lim);
    // Hold the read address during a stall so the registered data stays put.
    logic [IDX_BITS-1:0] k_idx, c_idx;
    assign k_idx   = k_reg[IDX_BITS-1:0];
    assign c_idx   = col_reg[IDX_BITS-1:0];
    assign a_raddr = stall ? a_raddr_reg : {row_reg, k_idx};
    assign b_raddr = stall ? b_raddr_reg : {k_idx, c_idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_raddr_reg <= '0;
            b_raddr_reg <= '0;
        end
        else
        begin
            a_raddr_reg <= a_raddr;
            b_raddr_reg <= b_raddr;
        end
    end

    mm_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(DEPTH)) u_a_ram (
        .clk(clk), .we(a_we), .waddr(waddr),
        .wdata(ELEMENT_BITS'(element_value)), .raddr(a_raddr), .rdata(a_rd)
    );
    mm_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(DEPTH)) u_b_ram (
        .clk(clk), .we(b_we), .waddr(waddr),
        .wdata(ELEMENT_BITS'(element_value)), .raddr(b_raddr), .rdata(b_rd)
    );

    // Issue one term per cycle unless the output stalls; an inner size of zero issues one zero term.
    logic    zero_inner;
    logic    last_term;
    mm_ctl_t issue_ctl, rd_ctl_reg, mul_ctl, acc_ctl;
    logic signed [OUT_BITS-1:0] mul_acc, acc_out;

    // Take a new transaction only once the read register and the multiply cell hold no valid term.
    assign ready = !busy_reg && !rd_ctl_reg.valid && !mul_ctl.valid;

    assign zero_inner = (inner_lim == '0);
    assign last_term  = zero_inner || (k_reg == inner_lim - 1'b1);

    always_comb
    begin
        issue_ctl           = '0;
        issue_ctl.valid     = issue;
        issue_ctl.first     = (k_reg == '0);
        issue_ctl.last_term = last_term;
        issue_ctl.last_col  = (col_reg == cols_lim - 1'b1);
        issue_ctl.col       = c_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
            k_reg    <= '0;
            row_reg  <= '0;
        end
        else if (in_acc && req_type == REQ_COMPUTE)
        begin
            if (CNT_BITS'(row_index) < rows_lim && cols_lim != '0)
            begin
                busy_reg <= 1'b1;
                row_reg  <= row_index;
                col_reg  <= '0;
                k_reg    <= '0;
            end
        end
        else if (issue)
        begin
            if (last_term)
            begin
                k_reg <= '0;
                if (col_reg == cols_lim - 1'b1)
                begin
                    busy_reg <= 1'b0;
                end
                col_reg <= col_reg + 1'b1;
            end
            else
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // Pause the chain while the output waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ctl_reg <= '0;
        end
        else if (!stall)
        begin
            rd_ctl_reg <= issue_ctl;
        end
    end

    logic signed [ELEMENT_BITS-1:0] a_term, b_term;
    assign a_term = zero_inner ? '0 : a_rd;
    assign b_term = zero_inner ? '0 : b_rd;

    mm_cell u_mul (
        .clk(clk), .rst_n(rst_n), .advance(!stall), .mul_en(1'b1),
        .a_in(a_term), .b_in(b_term), .acc_in('0),
        .ctl_in(rd_ctl_reg),
        .acc_out(mul_acc), .ctl_out(mul_ctl)
    );

    mm_cell u_acc (
        .clk(clk), .rst_n(rst_n), .advance(!stall), .mul_en(1'b0),
        .a_in('0), .b_in('0), .acc_in(mul_acc),
        .ctl_in(mul_ctl),
        .acc_out(acc_out), .ctl_out(acc_ctl)
    );

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else if (!stall)
        begin
            done_reg <= acc_ctl.valid && acc_ctl.last_term;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (!stall)
        begin
            out_valid <= mul_ctl.valid && mul_ctl.last_term;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall && mul_ctl.valid && mul_ctl.last_term)
        begin
            out_row       <= row_reg;
            out_col       <= mul_ctl.col;
            product_value <= mul_ctl.first ? mul_acc : acc_out + mul_acc;
            last_flag     <= mul_ctl.last_col;
        end
    end

    `ASSERT_IMPL(a_no_write_busy, clk, rst_n, (a_we || b_we) |-> !busy_reg)
    `ASSERT_IMPL(a_ready_idle, clk, rst_n, ready |-> !busy_reg)
    `ASSERT_IMPL(a_stall_hold, clk, rst_n,
        $past(stall) |-> $stable(product_value))
    `ASSERT_IMPL(a_done_idle, clk, rst_n,
        (done_reg && !busy_reg) |-> !issue)
    `ASSERT_NEVER(a_we_excl, clk, rst_n, a_we && b_we)
endmodule
